FILE: hdl/smvd_pkg.sv
package smvd_pkg;

	localparam int VALUES_PER_SEGMENT_DEF = 5;
	localparam int VALUE_BITS_DEF = 32;

	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [6:0] DIGIT_NONE = 7'd64;

	typedef enum logic [2:0] {
		ST_ENTRY = 3'd0,
		ST_END   = 3'd1,
		ST_BAD   = 3'd2,
		ST_EMPTY = 3'd3,
		ST_SHORT = 3'd4
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] orig_row;
		logic [31:0] orig_column;
		logic [30:0] gen_row;
		logic [31:0] gen_column;
		logic [31:0] source_index;
		logic [31:0] name_index;
		logic        final_result;
	} result_t;

	// base64 digit value, DIGIT_NONE when not a digit
	function automatic logic [6:0] digit_of(input logic [7:0] c);
		logic [6:0] d;
		d = DIGIT_NONE;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = 7'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			d = 7'd62;
		end else if (c == 8'h2F) begin
			d = 7'd63;
		end
		return d;
	endfunction

endpackage

FILE: hdl/smvd_rqueue.sv
module smvd_rqueue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  smvd_pkg::result_t push_a,
	input  smvd_pkg::result_t push_b,
	output logic              room,
	output logic              head_valid,
	input  logic              head_ready,
	output smvd_pkg::result_t head
);
	import smvd_pkg::*;

	result_t               entries_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]   wp_q;
	logic [RQ_PTR_W-1:0]   rp_q;
	logic [RQ_CNT_W-1:0]   cnt_q;
	logic [RQ_PTR_W-1:0]   wp_b;
	logic                  pop;

	assign wp_b = wp_q + 1'b1;
	assign pop = head_valid && head_ready;
	assign head_valid = (cnt_q != '0);
	assign head = entries_q[rp_q];
	// room for the two words one item can give
	assign room = (cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + RQ_PTR_W'(push_n);
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < RQ_DEPTH; i++) begin
			if (push_n != 2'd0 && RQ_PTR_W'(i) == wp_q) begin
				entries_q[i] <= push_a;
			end else if (push_n == 2'd2 && RQ_PTR_W'(i) == wp_b) begin
				entries_q[i] <= push_b;
			end
		end
	end

endmodule

FILE: hdl/source_map_vlq_mapping_decoder.sv
// A character is taken into the input register; its words then enter the result
// queue, which outputs one word per cycle while result_ready is high.
// Throughput: one character per cycle while the result queue has room; the
// segment state and the six running positions update once per character.
// Reset (arst_n low): positions, segment state and queue cleared, not halted.
module source_map_vlq_mapping_decoder #(
	parameter int VALUES_PER_SEGMENT = smvd_pkg::VALUES_PER_SEGMENT_DEF,
	parameter int VALUE_BITS = smvd_pkg::VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               symbol_valid,
	output logic               symbol_ready,
	input  logic [7:0]         symbol,
	input  logic               last_symbol,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [2:0]         status,
	output logic signed [31:0] orig_row,
	output logic signed [31:0] orig_column,
	output logic [30:0]        gen_row,
	output logic signed [31:0] gen_column,
	output logic signed [31:0] source_index,
	output logic signed [31:0] name_index,
	output logic               final_result
);
	import smvd_pkg::*;

	localparam int NAME_SLOT = VALUES_PER_SEGMENT - 1;

	// input stage
	logic                  valid_s1;
	logic [7:0]            sym_s1;
	logic                  last_s1;

	// segment state
	logic [VALUE_BITS-1:0] acc_q;
	logic [5:0]            shift_q;
	logic                  pend_q;
	logic                  nonempty_q;
	logic [2:0]            cnt_q;
	logic [31:0]           seg_q [VALUES_PER_SEGMENT];
	logic                  halt_q;

	// running positions
	logic [31:0]           orow_q, ocol_q, gcol_q, src_q, name_q;
	logic [30:0]           grow_q;

	logic                  room;
	logic                  fire;
	logic [1:0]            push_n;
	result_t               push_a, push_b, head;

	logic [6:0]            dig;
	logic                  is_comma, is_semi, is_digit, bad, cont;
	logic [VALUE_BITS-1:0] acc_t;
	logic [31:0]           mag, val;
	logic                  val_done;
	logic [VALUE_BITS-1:0] nx_acc;
	logic [5:0]            nx_shift;
	logic                  nx_pend, nx_nonempty;
	logic [2:0]            nx_cnt;
	logic [31:0]           seg_eff [VALUES_PER_SEGMENT];
	logic                  do_close, close_fail, err, close_ok, entry, end_ok;
	status_t               close_code, err_code;
	logic [31:0]           orow_p1, ocol_p1, gcol_p1, src_p1, name_p1, gcol_p2;
	logic [30:0]           grow_p2;
	result_t               entry_r, tail_r;

	assign fire = valid_s1 && room;
	assign symbol_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (symbol_ready) begin
			valid_s1 <= symbol_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (symbol_ready && symbol_valid) begin
			sym_s1 <= symbol;
			last_s1 <= last_symbol;
		end
	end

	// character decode and digit take
	always_comb begin
		dig = digit_of(sym_s1);
		is_comma = (sym_s1 == CH_COMMA);
		is_semi = (sym_s1 == CH_SEMI);
		is_digit = !is_comma && !is_semi && (dig != DIGIT_NONE);
		bad = !is_comma && !is_semi && !is_digit;
		cont = dig[5];
		acc_t = acc_q + (VALUE_BITS'(dig[4:0]) << shift_q);
		mag = 32'(acc_t) >> 1;
		val = acc_t[0] ? (32'd0 - mag) : mag;
		val_done = is_digit && !cont;

		nx_acc = acc_q;
		nx_shift = shift_q;
		nx_pend = pend_q;
		nx_nonempty = nonempty_q;
		nx_cnt = cnt_q;
		if (is_digit) begin
			nx_nonempty = 1'b1;
			if (cont) begin
				nx_acc = acc_t;
				nx_pend = 1'b1;
				if (32'(shift_q) < VALUE_BITS) begin
					nx_shift = shift_q + 6'd5;
				end
			end else begin
				nx_acc = '0;
				nx_shift = '0;
				nx_pend = 1'b0;
				if (cnt_q < 3'd6) begin
					nx_cnt = cnt_q + 3'd1;
				end
			end
		end
		for (int i = 0; i < VALUES_PER_SEGMENT; i++) begin
			seg_eff[i] = (val_done && 32'(cnt_q) == i) ? val : seg_q[i];
		end
	end

	// segment close
	always_comb begin
		do_close = is_comma || is_semi || (is_digit && last_s1);
		close_fail = 1'b1;
		close_code = ST_BAD;
		priority if (!nx_nonempty) begin
			close_fail = is_comma;
			close_code = ST_EMPTY;
		end else if (nx_pend) begin
			close_code = ST_BAD;
		end else if (nx_cnt == 3'd0) begin
			close_code = ST_EMPTY;
		end else if (nx_cnt == 3'd2 || nx_cnt == 3'd3) begin
			close_code = ST_SHORT;
		end else begin
			close_fail = 1'b0;
		end
		err = bad || (do_close && close_fail);
		err_code = bad ? ST_BAD : close_code;
		close_ok = do_close && !err;
		entry = close_ok && nx_nonempty && (nx_cnt >= 3'd4);
		end_ok = last_s1 && !err;

		orow_p1 = orow_q;
		ocol_p1 = ocol_q;
		src_p1 = src_q;
		name_p1 = name_q;
		gcol_p1 = gcol_q;
		if (close_ok && nx_nonempty) begin
			gcol_p1 = gcol_q + seg_eff[0];
		end
		if (entry) begin
			src_p1 = src_q + seg_eff[1];
			orow_p1 = orow_q + seg_eff[2];
			ocol_p1 = ocol_q + seg_eff[3];
			if (VALUES_PER_SEGMENT > 4 && nx_cnt == 3'd5) begin
				name_p1 = name_q + seg_eff[NAME_SLOT];
			end
		end
		grow_p2 = grow_q;
		gcol_p2 = gcol_p1;
		if (is_semi && close_ok) begin
			grow_p2 = grow_q + 31'd1;
			gcol_p2 = '0;
		end
	end

	// result words
	always_comb begin
		entry_r.status = ST_ENTRY;
		entry_r.orig_row = orow_p1;
		entry_r.orig_column = ocol_p1;
		entry_r.gen_row = grow_q;
		entry_r.gen_column = gcol_p1;
		entry_r.source_index = src_p1;
		entry_r.name_index = name_p1;
		entry_r.final_result = !(end_ok || err);

		tail_r.status = err ? err_code : ST_END;
		tail_r.orig_row = orow_p1;
		tail_r.orig_column = ocol_p1;
		tail_r.gen_row = grow_p2;
		tail_r.gen_column = gcol_p2;
		tail_r.source_index = src_p1;
		tail_r.name_index = name_p1;
		tail_r.final_result = 1'b1;

		push_n = 2'd0;
		if (fire && !halt_q) begin
			push_n = 2'(entry) + 2'(end_ok || err);
		end
		push_a = entry ? entry_r : tail_r;
		push_b = tail_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			shift_q <= '0;
			pend_q <= 1'b0;
			nonempty_q <= 1'b0;
			cnt_q <= '0;
			halt_q <= 1'b0;
			orow_q <= '0;
			ocol_q <= '0;
			grow_q <= '0;
			gcol_q <= '0;
			src_q <= '0;
			name_q <= '0;
		end else if (fire) begin
			if (last_s1) begin
				acc_q <= '0;
				shift_q <= '0;
				pend_q <= 1'b0;
				nonempty_q <= 1'b0;
				cnt_q <= '0;
				halt_q <= 1'b0;
				orow_q <= '0;
				ocol_q <= '0;
				grow_q <= '0;
				gcol_q <= '0;
				src_q <= '0;
				name_q <= '0;
			end else if (!halt_q) begin
				if (err) begin
					halt_q <= 1'b1;
				end else begin
					if (close_ok) begin
						acc_q <= '0;
						shift_q <= '0;
						pend_q <= 1'b0;
						nonempty_q <= 1'b0;
						cnt_q <= '0;
					end else begin
						acc_q <= nx_acc;
						shift_q <= nx_shift;
						pend_q <= nx_pend;
						nonempty_q <= nx_nonempty;
						cnt_q <= nx_cnt;
					end
					orow_q <= orow_p1;
					ocol_q <= ocol_p1;
					grow_q <= grow_p2;
					gcol_q <= gcol_p2;
					src_q <= src_p1;
					name_q <= name_p1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < VALUES_PER_SEGMENT; i++) begin
			if (fire && !halt_q && val_done && 32'(cnt_q) == i) begin
				seg_q[i] <= val;
			end
		end
	end

	smvd_rqueue u_rqueue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_a     (push_a),
		.push_b     (push_b),
		.room       (room),
		.head_valid (result_valid),
		.head_ready (result_ready),
		.head       (head)
	);

	assign status = head.status;
	assign orig_row = head.orig_row;
	assign orig_column = head.orig_column;
	assign gen_row = head.gen_row;
	assign gen_column = head.gen_column;
	assign source_index = head.source_index;
	assign name_index = head.name_index;
	assign final_result = head.final_result;

endmodule
